FILE: src/tvv_pkg.sv
package tvv_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int TOL_WIDTH   = (VALUE_WIDTH > 32) ? VALUE_WIDTH : 32;

  // magnitude of a three-term sum, split into digits for the divide by three
  localparam int MAG_WIDTH   = VALUE_WIDTH + 1;
  localparam int DIGIT_WIDTH = 8;
  localparam int NUM_DIGITS  = (MAG_WIDTH + DIGIT_WIDTH - 1) / DIGIT_WIDTH;
  localparam int PAD_WIDTH   = NUM_DIGITS * DIGIT_WIDTH;
  localparam int CUR_WIDTH   = DIGIT_WIDTH + 2;
  localparam int PROD_WIDTH  = CUR_WIDTH + 10;

  // floor(x / 3) == (x * 683) >> 11 for every x below 1024
  localparam int RECIP3      = 683;
  localparam int RECIP_SHIFT = 11;

  localparam logic [1:0] ODD_FIRST  = 2'd0;
  localparam logic [1:0] ODD_SECOND = 2'd1;
  localparam logic [1:0] ODD_THIRD  = 2'd2;
  localparam logic [1:0] ODD_NONE   = 2'd3;

  typedef logic [VALUE_WIDTH-1:0] value_t;
  typedef logic [VALUE_WIDTH:0]   wide_t;
  typedef logic [TOL_WIDTH-1:0]   tol_t;

  // differences and sums of the three copies
  typedef struct packed {
    value_t                 a;
    value_t                 b;
    value_t                 c;
    wide_t                  d12;
    wide_t                  d23;
    wide_t                  d13;
    wide_t                  s12;
    wide_t                  s23;
    wide_t                  s13;
    logic [VALUE_WIDTH+1:0] s3;
  } front_t;

  // one item inside the divide pipeline
  typedef struct packed {
    logic                 use_div;
    logic                 neg;
    logic [PAD_WIDTH-1:0] mag;
    logic [1:0]           rem;
    logic [PAD_WIDTH-1:0] quo;
    value_t               value;
    logic                 all_agree;
    logic [1:0]           odd;
    value_t               maxd;
  } dstage_t;

endpackage

FILE: src/tvv_front.sv
module tvv_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  tvv_pkg::value_t in_a,
  input  tvv_pkg::value_t in_b,
  input  tvv_pkg::value_t in_c,
  output logic            out_valid,
  input  logic            out_ready,
  output tvv_pkg::front_t out_data
);
  import tvv_pkg::*;

  logic   vld_r;
  front_t data_r, data_nxt;

  assign in_ready  = !vld_r || out_ready;
  assign out_valid = vld_r;
  assign out_data  = data_r;

  always_comb begin
    data_nxt.a   = in_a;
    data_nxt.b   = in_b;
    data_nxt.c   = in_c;
    data_nxt.d12 = {in_a[VALUE_WIDTH-1], in_a} - {in_b[VALUE_WIDTH-1], in_b};
    data_nxt.d23 = {in_b[VALUE_WIDTH-1], in_b} - {in_c[VALUE_WIDTH-1], in_c};
    data_nxt.d13 = {in_a[VALUE_WIDTH-1], in_a} - {in_c[VALUE_WIDTH-1], in_c};
    data_nxt.s12 = {in_a[VALUE_WIDTH-1], in_a} + {in_b[VALUE_WIDTH-1], in_b};
    data_nxt.s23 = {in_b[VALUE_WIDTH-1], in_b} + {in_c[VALUE_WIDTH-1], in_c};
    data_nxt.s13 = {in_a[VALUE_WIDTH-1], in_a} + {in_c[VALUE_WIDTH-1], in_c};
    data_nxt.s3  = {{2{in_a[VALUE_WIDTH-1]}}, in_a} + {{2{in_b[VALUE_WIDTH-1]}}, in_b}
                 + {{2{in_c[VALUE_WIDTH-1]}}, in_c};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

FILE: src/tvv_decide.sv
module tvv_decide (
  input  logic             clk,
  input  logic             rst_n,
  input  tvv_pkg::tol_t    tolerance,
  input  logic             in_valid,
  output logic             in_ready,
  input  tvv_pkg::front_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output tvv_pkg::dstage_t out_data
);
  import tvv_pkg::*;

  logic    vld_r;
  dstage_t data_r, data_nxt;

  wide_t                  neg12, neg23, neg13;
  value_t                 m12, m23, m13;
  logic                   g12, g23, g13;
  value_t                 mean12, mean23, mean13;
  logic [VALUE_WIDTH+1:0] neg3;
  logic [MAG_WIDTH-1:0]   mag3;
  logic                   swap, c_le_lo, hi_lt_c;
  value_t                 lo, hi, median;

  // mean of two, truncated toward zero
  function automatic value_t half_trunc(input wide_t s);
    wide_t t;
    t = {s[VALUE_WIDTH], s[VALUE_WIDTH:1]} + {{VALUE_WIDTH{1'b0}}, s[VALUE_WIDTH] & s[0]};
    return t[VALUE_WIDTH-1:0];
  endfunction

  assign in_ready  = !vld_r || out_ready;
  assign out_valid = vld_r;
  assign out_data  = data_r;

  always_comb begin
    neg12 = '0 - in_data.d12;
    neg23 = '0 - in_data.d23;
    neg13 = '0 - in_data.d13;
    m12 = in_data.d12[VALUE_WIDTH] ? neg12[VALUE_WIDTH-1:0] : in_data.d12[VALUE_WIDTH-1:0];
    m23 = in_data.d23[VALUE_WIDTH] ? neg23[VALUE_WIDTH-1:0] : in_data.d23[VALUE_WIDTH-1:0];
    m13 = in_data.d13[VALUE_WIDTH] ? neg13[VALUE_WIDTH-1:0] : in_data.d13[VALUE_WIDTH-1:0];

    g12 = TOL_WIDTH'(m12) <= tolerance;
    g23 = TOL_WIDTH'(m23) <= tolerance;
    g13 = TOL_WIDTH'(m13) <= tolerance;

    mean12 = half_trunc(in_data.s12);
    mean23 = half_trunc(in_data.s23);
    mean13 = half_trunc(in_data.s13);

    neg3 = '0 - in_data.s3;
    mag3 = in_data.s3[VALUE_WIDTH+1] ? neg3[MAG_WIDTH-1:0] : in_data.s3[MAG_WIDTH-1:0];

    // median from the signs of the differences; ties pick equal values
    swap    = !in_data.d12[VALUE_WIDTH];
    lo      = swap ? in_data.b : in_data.a;
    hi      = swap ? in_data.a : in_data.b;
    c_le_lo = swap ? !in_data.d23[VALUE_WIDTH] : !in_data.d13[VALUE_WIDTH];
    hi_lt_c = swap ? in_data.d13[VALUE_WIDTH] : in_data.d23[VALUE_WIDTH];
    median  = c_le_lo ? lo : (hi_lt_c ? hi : in_data.c);

    data_nxt.use_div   = 1'b0;
    data_nxt.neg       = in_data.s3[VALUE_WIDTH+1];
    data_nxt.mag       = PAD_WIDTH'(mag3);
    data_nxt.rem       = 2'd0;
    data_nxt.quo       = '0;
    data_nxt.all_agree = 1'b0;
    data_nxt.odd       = ODD_NONE;
    data_nxt.value     = median;

    if (m12 >= m23 && m12 >= m13) begin
      data_nxt.maxd = m12;
    end else if (m23 >= m13) begin
      data_nxt.maxd = m23;
    end else begin
      data_nxt.maxd = m13;
    end

    priority if (g12 && g23 && g13) begin
      data_nxt.use_div   = 1'b1;
      data_nxt.all_agree = 1'b1;
    end else if (g12) begin
      data_nxt.value = mean12;
      data_nxt.odd   = ODD_THIRD;
    end else if (g23) begin
      data_nxt.value = mean23;
      data_nxt.odd   = ODD_FIRST;
    end else if (g13) begin
      data_nxt.value = mean13;
      data_nxt.odd   = ODD_SECOND;
    end else begin
      data_nxt.value = median;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

FILE: src/tvv_div3.sv
module tvv_div3 (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  tvv_pkg::dstage_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output tvv_pkg::value_t  out_voted_value,
  output logic             out_all_agree,
  output logic [1:0]       out_odd_copy,
  output tvv_pkg::value_t  out_peak_diff
);
  import tvv_pkg::*;

  wire dstage_t           st_q [NUM_DIGITS];
  wire [NUM_DIGITS-1:0]   vld_q;
  wire [NUM_DIGITS:0]     rdy;

  logic                   out_vld_r;
  value_t                 value_r, value_nxt;
  logic                   agree_r;
  logic [1:0]             odd_r;
  value_t                 maxd_r;
  logic [PAD_WIDTH-1:0]   quo_neg;

  assign in_ready         = rdy[0];
  assign rdy[NUM_DIGITS]  = !out_vld_r || out_ready;

  // one quotient digit per stage, most significant first
  for (genvar g = 0; g < NUM_DIGITS; g++) begin : g_digit
    dstage_t               src, stage_r, stage_nxt;
    logic                  src_vld, vld_r;
    logic [CUR_WIDTH-1:0]  cur, rem_full;
    logic [PROD_WIDTH-1:0] prod;
    logic [DIGIT_WIDTH-1:0] qd;

    if (g == 0) begin : g_head
      assign src     = in_data;
      assign src_vld = in_valid;
    end else begin : g_body
      assign src     = st_q[g-1];
      assign src_vld = vld_q[g-1];
    end

    assign rdy[g]   = !vld_r || rdy[g+1];
    assign st_q[g]  = stage_r;
    assign vld_q[g] = vld_r;

    always_comb begin
      cur       = {src.rem, src.mag[PAD_WIDTH-1 -: DIGIT_WIDTH]};
      prod      = PROD_WIDTH'(cur) * PROD_WIDTH'(RECIP3);
      qd        = prod[RECIP_SHIFT +: DIGIT_WIDTH];
      rem_full  = cur - ((CUR_WIDTH'(qd) << 1) + CUR_WIDTH'(qd));
      stage_nxt     = src;
      stage_nxt.rem = rem_full[1:0];
      stage_nxt.mag = src.mag << DIGIT_WIDTH;
      stage_nxt.quo = {src.quo[PAD_WIDTH-DIGIT_WIDTH-1:0], qd};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else if (rdy[g]) begin
        vld_r <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[g] && src_vld) begin
        stage_r <= stage_nxt;
      end
    end
  end

  // apply the sign and pick the three-way mean where needed
  always_comb begin
    quo_neg = '0 - st_q[NUM_DIGITS-1].quo;
    if (st_q[NUM_DIGITS-1].use_div) begin
      value_nxt = st_q[NUM_DIGITS-1].neg ? quo_neg[VALUE_WIDTH-1:0]
                                         : st_q[NUM_DIGITS-1].quo[VALUE_WIDTH-1:0];
    end else begin
      value_nxt = st_q[NUM_DIGITS-1].value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (rdy[NUM_DIGITS]) begin
      out_vld_r <= vld_q[NUM_DIGITS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[NUM_DIGITS] && vld_q[NUM_DIGITS-1]) begin
      value_r <= value_nxt;
      agree_r <= st_q[NUM_DIGITS-1].all_agree;
      odd_r   <= st_q[NUM_DIGITS-1].odd;
      maxd_r  <= st_q[NUM_DIGITS-1].maxd;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_voted_value = value_r;
  assign out_all_agree   = agree_r;
  assign out_odd_copy    = odd_r;
  assign out_peak_diff   = maxd_r;

endmodule

FILE: src/tolerance_tmr_voter.sv
// Three-copy voter with a tolerance window.
// Input channel (in_valid/in_ready) carries three signed Q16.16 copies of one
// value; the result channel (out_valid/out_ready) returns the voted value,
// an all-agree flag, the index of the odd copy (3 for none) and the largest
// pairwise absolute difference. Two copies agree when their difference is at
// most the tolerance written through cfg_wr_en/cfg_wr_data.
// All three agree: mean of three, truncated toward zero. Else the first
// agreeing pair (1-2, 2-3, 1-3) gives its mean. No pair agrees: median.
// The path from input transfer to output valid is one stage of
// differences and sums, one stage of tolerance compares and selection, five
// stages of the divide by three (one 8-bit quotient digit each) and the
// output register. One item is accepted every cycle when out_ready is high.
// Every stage holds its valid bit with its data; when the receiver stalls,
// stages fill up from the output backward and in_ready drops only once the
// whole pipeline is full, so nothing is lost or repeated.
// Reset (synchronous, rst_n low) empties the pipeline and clears the
// tolerance to zero. Write the tolerance only while the pipeline is empty.
module tolerance_tmr_voter (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_wr_en,
  input  tvv_pkg::tol_t   cfg_wr_data,
  input  logic            in_valid,
  output logic            in_ready,
  input  tvv_pkg::value_t in_copy_first,
  input  tvv_pkg::value_t in_copy_second,
  input  tvv_pkg::value_t in_copy_third,
  output logic            out_valid,
  input  logic            out_ready,
  output tvv_pkg::value_t out_voted_value,
  output logic            out_all_agree,
  output logic [1:0]      out_odd_copy,
  output tvv_pkg::value_t out_peak_diff
);
  import tvv_pkg::*;

  tol_t    tol_r;
  logic    fr_valid, fr_ready;
  front_t  fr_data;
  logic    dc_valid, dc_ready;
  dstage_t dc_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= '0;
    end else if (cfg_wr_en) begin
      tol_r <= cfg_wr_data;
    end
  end

  tvv_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_a      (in_copy_first),
    .in_b      (in_copy_second),
    .in_c      (in_copy_third),
    .out_valid (fr_valid),
    .out_ready (fr_ready),
    .out_data  (fr_data)
  );

  tvv_decide u_decide (
    .clk       (clk),
    .rst_n     (rst_n),
    .tolerance (tol_r),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .in_data   (fr_data),
    .out_valid (dc_valid),
    .out_ready (dc_ready),
    .out_data  (dc_data)
  );

  tvv_div3 u_div3 (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (dc_valid),
    .in_ready        (dc_ready),
    .in_data         (dc_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_voted_value (out_voted_value),
    .out_all_agree   (out_all_agree),
    .out_odd_copy    (out_odd_copy),
    .out_peak_diff   (out_peak_diff)
  );

endmodule
